// ----- design/tbc_pkg.sv -----
`timescale 1ns / 1ps

package tbc_pkg;

  localparam logic [7:0]  FLAG_HEADER = 8'h00;
  localparam logic [7:0]  FLAG_DATA   = 8'hff;
  localparam logic [15:0] HEADER_LEN  = 16'd19;

  // body byte positions of the decoded header fields
  localparam logic [15:0] IDX_FLAG    = 16'd0;
  localparam logic [15:0] IDX_KIND    = 16'd1;
  localparam logic [15:0] IDX_HLEN_LO = 16'd12;
  localparam logic [15:0] IDX_HLEN_HI = 16'd13;
  localparam logic [15:0] IDX_HSTA_LO = 16'd14;
  localparam logic [15:0] IDX_HSTA_HI = 16'd15;

  typedef enum logic [1:0] {
    PH_LEN_LO,
    PH_LEN_HI,
    PH_BODY
  } phase_t;

  typedef enum logic [2:0] {
    CLS_EMPTY,
    CLS_HEADER,
    CLS_DATA,
    CLS_OTHER,
    CLS_NOFLAG
  } block_class_t;

  typedef enum logic [1:0] {
    SUM_MATCH,
    SUM_MISMATCH,
    SUM_UNCHECKED
  } sum_status_t;

  typedef struct packed {
    logic [15:0]  block_number;
    block_class_t block_class;
    logic [15:0]  data_size;
    logic [7:0]   flag_value;
    logic [7:0]   stored_sum;
    logic [7:0]   computed_sum;
    sum_status_t  sum_status;
    logic [16:0]  missing_bytes;
    logic [7:0]   header_kind;
    logic [15:0]  header_length;
    logic [15:0]  header_start;
    logic         final_result;
  } result_t;

  function automatic block_class_t class_of_flag(input logic [7:0] flag,
                                                 input logic [15:0] len);
    block_class_t cls;
    if (flag == FLAG_HEADER && len == HEADER_LEN) begin
      cls = CLS_HEADER;
    end else if (flag == FLAG_DATA) begin
      cls = CLS_DATA;
    end else begin
      cls = CLS_OTHER;
    end
    return cls;
  endfunction

  function automatic logic [15:0] size_of(input logic [15:0] len);
    return (len >= 16'd2) ? len - 16'd2 : 16'd0;
  endfunction

endpackage

// ----- design/tape_block_checker.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Payload
// in_*      input      in_valid / in_stall   data_byte, end_of_image
// out_*     output     out_valid / out_stall block report, final_result
//
// One byte per cycle while in_stall is low. A result is registered into
// the main entry of the two-entry output buffer, or into its skid entry
// while the main entry is held. Reset (rst_n low, synchronous) returns
// to the start of an image with block number 1. in_stall rises only when
// both output entries are held by a stalled receiver.

module tape_block_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_image,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_block_number,
  output logic [2:0]  out_block_class,
  output logic [15:0] out_data_size,
  output logic [7:0]  out_flag_value,
  output logic [7:0]  out_stored_sum,
  output logic [7:0]  out_computed_sum,
  output logic [1:0]  out_sum_status,
  output logic [16:0] out_missing_bytes,
  output logic [7:0]  out_header_kind,
  output logic [15:0] out_header_length,
  output logic [15:0] out_header_start,
  output logic        out_final_result
);

  logic             beat;
  logic             res_valid;
  tbc_pkg::result_t res;
  tbc_pkg::result_t out_data;

  assign beat = in_valid && !in_stall;

  tbc_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .beat         (beat),
    .data_byte    (in_data_byte),
    .end_of_image (in_end_of_image),
    .res_valid    (res_valid),
    .res          (res)
  );

  tbc_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_block_number  = out_data.block_number;
  assign out_block_class   = out_data.block_class;
  assign out_data_size     = out_data.data_size;
  assign out_flag_value    = out_data.flag_value;
  assign out_stored_sum    = out_data.stored_sum;
  assign out_computed_sum  = out_data.computed_sum;
  assign out_sum_status    = out_data.sum_status;
  assign out_missing_bytes = out_data.missing_bytes;
  assign out_header_kind   = out_data.header_kind;
  assign out_header_length = out_data.header_length;
  assign out_header_start  = out_data.header_start;
  assign out_final_result  = out_data.final_result;

endmodule

// ----- design/tbc_parser.sv -----
`timescale 1ns / 1ps

module tbc_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             beat,
  input  logic [7:0]       data_byte,
  input  logic             end_of_image,
  output logic             res_valid,
  output tbc_pkg::result_t res
);

  tbc_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  len_lo_r, len_lo_nxt;
  logic [15:0] blk_len_r, blk_len_nxt;
  logic [15:0] left_r, left_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [7:0]  flag_r, flag_nxt;
  logic [7:0]  kind_r, kind_nxt;
  logic [15:0] hlen_r, hlen_nxt;
  logic [15:0] hsta_r, hsta_nxt;
  logic [15:0] count_r, count_nxt;

  logic [15:0] len_full;
  logic [15:0] idx;
  logic [15:0] left_dec;
  logic [7:0]  flag_upd;
  logic [7:0]  kind_upd;
  logic [15:0] hlen_upd;
  logic [15:0] hsta_upd;
  tbc_pkg::block_class_t body_cls;

  assign len_full = {data_byte, len_lo_r};
  assign idx      = blk_len_r - left_r;
  assign left_dec = left_r - 16'd1;

  // holds as they stand after this body byte
  always_comb begin
    flag_upd = flag_r;
    kind_upd = kind_r;
    hlen_upd = hlen_r;
    hsta_upd = hsta_r;
    unique case (idx)
      tbc_pkg::IDX_FLAG:    flag_upd       = data_byte;
      tbc_pkg::IDX_KIND:    kind_upd       = data_byte;
      tbc_pkg::IDX_HLEN_LO: hlen_upd[7:0]  = data_byte;
      tbc_pkg::IDX_HLEN_HI: hlen_upd[15:8] = data_byte;
      tbc_pkg::IDX_HSTA_LO: hsta_upd[7:0]  = data_byte;
      tbc_pkg::IDX_HSTA_HI: hsta_upd[15:8] = data_byte;
      default: ;
    endcase
  end

  assign body_cls = tbc_pkg::class_of_flag(flag_upd, blk_len_r);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (beat) begin
      unique case (phase_r)
        tbc_pkg::PH_LEN_HI: begin
          if (len_full == 16'd0 || end_of_image) phase_nxt = tbc_pkg::PH_LEN_LO;
          else                                   phase_nxt = tbc_pkg::PH_BODY;
        end
        tbc_pkg::PH_BODY: begin
          if (left_dec == 16'd0 || end_of_image) phase_nxt = tbc_pkg::PH_LEN_LO;
        end
        default: begin
          if (end_of_image) phase_nxt = tbc_pkg::PH_LEN_LO;
          else              phase_nxt = tbc_pkg::PH_LEN_HI;
        end
      endcase
    end
  end

  // datapath and result
  always_comb begin
    len_lo_nxt  = len_lo_r;
    blk_len_nxt = blk_len_r;
    left_nxt    = left_r;
    xor_nxt     = xor_r;
    flag_nxt    = flag_r;
    kind_nxt    = kind_r;
    hlen_nxt    = hlen_r;
    hsta_nxt    = hsta_r;
    res_valid   = 1'b0;

    res.block_number  = count_r;
    res.block_class   = tbc_pkg::CLS_EMPTY;
    res.data_size     = 16'd0;
    res.flag_value    = 8'd0;
    res.stored_sum    = 8'd0;
    res.computed_sum  = 8'd0;
    res.sum_status    = tbc_pkg::SUM_UNCHECKED;
    res.missing_bytes = 17'd0;
    res.header_kind   = 8'd0;
    res.header_length = 16'd0;
    res.header_start  = 16'd0;
    res.final_result  = end_of_image;

    if (beat) begin
      unique case (phase_r)
        tbc_pkg::PH_LEN_HI: begin
          blk_len_nxt    = len_full;
          left_nxt       = len_full;
          xor_nxt        = 8'd0;
          flag_nxt       = 8'd0;
          kind_nxt       = 8'd0;
          hlen_nxt       = 16'd0;
          hsta_nxt       = 16'd0;
          res.data_size  = tbc_pkg::size_of(len_full);
          if (len_full == 16'd0) begin
            left_nxt  = 16'd0;
            res_valid = 1'b1;
          end else if (end_of_image) begin
            res_valid         = 1'b1;
            res.block_class   = tbc_pkg::CLS_NOFLAG;
            res.missing_bytes = {1'b0, len_full};
          end
        end
        tbc_pkg::PH_BODY: begin
          flag_nxt          = flag_upd;
          kind_nxt          = kind_upd;
          hlen_nxt          = hlen_upd;
          hsta_nxt          = hsta_upd;
          left_nxt          = left_dec;
          res.block_class   = body_cls;
          res.data_size     = tbc_pkg::size_of(blk_len_r);
          res.flag_value    = flag_upd;
          if (left_dec == 16'd0) begin
            res_valid        = 1'b1;
            res.computed_sum = xor_r;
            if (blk_len_r > 16'd1) begin
              res.stored_sum = data_byte;
              res.sum_status = (data_byte == xor_r) ? tbc_pkg::SUM_MATCH
                                                    : tbc_pkg::SUM_MISMATCH;
            end
            if (body_cls == tbc_pkg::CLS_HEADER) begin
              res.header_kind   = kind_upd;
              res.header_length = hlen_upd;
              res.header_start  = hsta_upd;
            end
          end else begin
            xor_nxt          = xor_r ^ data_byte;
            res.computed_sum = xor_r ^ data_byte;
            if (end_of_image) begin
              res_valid         = 1'b1;
              res.missing_bytes = {1'b0, left_dec};
            end
          end
        end
        default: begin
          len_lo_nxt = data_byte;
          if (end_of_image) begin
            res_valid         = 1'b1;
            res.block_class   = (data_byte == 8'd0) ? tbc_pkg::CLS_EMPTY
                                                    : tbc_pkg::CLS_NOFLAG;
            res.data_size     = tbc_pkg::size_of({8'd0, data_byte});
            res.missing_bytes = {9'd0, data_byte} + 17'd1;
          end
        end
      endcase
    end

    count_nxt = count_r;
    if (res_valid && count_r != 16'hffff) count_nxt = count_r + 16'd1;
  end

  always_ff @(posedge clk) begin
    // a closing result starts the next image from the reset state
    if (!rst_n || (res_valid && end_of_image)) begin
      phase_r  <= tbc_pkg::PH_LEN_LO;
      len_lo_r <= 8'd0;
      blk_len_r <= 16'd0;
      left_r   <= 16'd0;
      xor_r    <= 8'd0;
      flag_r   <= 8'd0;
      kind_r   <= 8'd0;
      hlen_r   <= 16'd0;
      hsta_r   <= 16'd0;
      count_r  <= 16'd1;
    end else begin
      phase_r  <= phase_nxt;
      len_lo_r <= len_lo_nxt;
      blk_len_r <= blk_len_nxt;
      left_r   <= left_nxt;
      xor_r    <= xor_nxt;
      flag_r   <= flag_nxt;
      kind_r   <= kind_nxt;
      hlen_r   <= hlen_nxt;
      hsta_r   <= hsta_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- design/tbc_out_buf.sv -----
`timescale 1ns / 1ps

module tbc_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tbc_pkg::result_t push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output tbc_pkg::result_t out_data
);

  logic             main_valid_r, main_valid_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  tbc_pkg::result_t main_r, main_nxt;
  tbc_pkg::result_t skid_r, skid_nxt;
  logic             take;

  assign take      = main_valid_r && !out_stall;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;
  assign full      = skid_valid_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      // no push can arrive while the skid holds a beat
      if (take) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || take) begin
        main_nxt       = push_data;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (take) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int DIR_ROWS = 25;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_mode_t;

  typedef struct {
    logic [7:0]       data;
    logic             eoi;
    bit               typed;
    bit               drain_before;
    tbc_pkg::result_t want;
  } tape_beat_t;

  // {end_of_image, data_byte}
  localparam logic [8:0] DIR_BEATS [DIR_ROWS] = '{
    9'h100,                          // lone zero length byte ends the image
    9'h1ff,                          // lone nonzero length byte ends the image
    9'h000, 9'h000,                  // empty block
    9'h001, 9'h000, 9'h0ff,          // length one: flag only
    9'h002, 9'h000, 9'h0ab, 9'h0ab,  // shortest checked block, sums match
    9'h002, 9'h000, 9'h0ab, 9'h0ac,  // same, sums differ
    9'h003, 9'h100,                  // image ends right after the length
    9'h004, 9'h000, 9'h0ff, 9'h112,  // image ends inside a body
    9'h0ff, 9'h1ff,                  // largest length, image ends after it
    9'h000, 9'h100                   // empty block closes the image
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_end_of_image = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_block_number;
  logic [2:0]  out_block_class;
  logic [15:0] out_data_size;
  logic [7:0]  out_flag_value;
  logic [7:0]  out_stored_sum;
  logic [7:0]  out_computed_sum;
  logic [1:0]  out_sum_status;
  logic [16:0] out_missing_bytes;
  logic [7:0]  out_header_kind;
  logic [15:0] out_header_length;
  logic [15:0] out_header_start;
  logic        out_final_result;

  tape_beat_t       tape_q[$];
  tbc_pkg::result_t pending_reports[$];
  tbc_pkg::result_t dir_want [DIR_ROWS] = '{default: '0};
  int               in_row = 0;
  int               mismatch_count = 0;
  int               cycle_count = 0;
  int               cycle_limit = 32'h7fff_ffff;
  stall_mode_t      stall_mode = STALL_NONE;
  int               stall_span = 0;

  // parser state of the predictor
  tbc_pkg::phase_t parse_phase;
  logic [7:0]      len_lo_q;
  logic [15:0]     blk_len_q;
  logic [15:0]     left_q;
  logic [7:0]      xor_q;
  logic [7:0]      flag_q;
  logic [7:0]      kind_q;
  logic [15:0]     hdr_len_q;
  logic [15:0]     hdr_start_q;
  logic [15:0]     blk_num_q;

  tape_block_checker DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_end_of_image  (in_end_of_image),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_block_number (out_block_number),
    .out_block_class  (out_block_class),
    .out_data_size    (out_data_size),
    .out_flag_value   (out_flag_value),
    .out_stored_sum   (out_stored_sum),
    .out_computed_sum (out_computed_sum),
    .out_sum_status   (out_sum_status),
    .out_missing_bytes(out_missing_bytes),
    .out_header_kind  (out_header_kind),
    .out_header_length(out_header_length),
    .out_header_start (out_header_start),
    .out_final_result (out_final_result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic clear_body();
    left_q      = '0;
    xor_q       = '0;
    flag_q      = '0;
    kind_q      = '0;
    hdr_len_q   = '0;
    hdr_start_q = '0;
  endtask

  task automatic restart_image();
    parse_phase = tbc_pkg::PH_LEN_LO;
    len_lo_q    = '0;
    blk_len_q   = '0;
    clear_body();
    blk_num_q   = 16'd1;
  endtask

  task automatic close_block(input tbc_pkg::block_class_t cls, input logic [7:0] stored,
                             input tbc_pkg::sum_status_t st, input logic [16:0] missing,
                             input logic fin, input bit hdr,
                             output tbc_pkg::result_t rep);
    rep.block_number  = blk_num_q;
    rep.block_class   = cls;
    rep.data_size     = (blk_len_q >= 16'd2) ? blk_len_q - 16'd2 : 16'd0;
    rep.flag_value    = flag_q;
    rep.stored_sum    = stored;
    rep.computed_sum  = xor_q;
    rep.sum_status    = st;
    rep.missing_bytes = missing;
    rep.header_kind   = hdr ? kind_q : 8'h00;
    rep.header_length = hdr ? hdr_len_q : 16'h0000;
    rep.header_start  = hdr ? hdr_start_q : 16'h0000;
    rep.final_result  = fin;
    if (blk_num_q != 16'hffff) begin
      blk_num_q = blk_num_q + 16'd1;
    end
    if (fin) begin
      restart_image();
    end
  endtask

  task automatic parse_tape_byte(input logic [7:0] b, input logic eoi,
                                 output bit produced, output tbc_pkg::result_t rep);
    logic [15:0]           pos;
    tbc_pkg::block_class_t cls;
    logic [7:0]            stored;
    tbc_pkg::sum_status_t  st;
    produced = 1'b1;
    rep = '0;
    case (parse_phase)
      tbc_pkg::PH_LEN_HI: begin
        blk_len_q = {b, len_lo_q};
        clear_body();
        if (blk_len_q == 16'd0) begin
          parse_phase = tbc_pkg::PH_LEN_LO;
          close_block(tbc_pkg::CLS_EMPTY, 8'h00, tbc_pkg::SUM_UNCHECKED, '0, eoi,
                      1'b0, rep);
        end else if (eoi) begin
          close_block(tbc_pkg::CLS_NOFLAG, 8'h00, tbc_pkg::SUM_UNCHECKED,
                      {1'b0, blk_len_q}, 1'b1, 1'b0, rep);
        end else begin
          left_q = blk_len_q;
          parse_phase = tbc_pkg::PH_BODY;
          produced = 1'b0;
        end
      end
      tbc_pkg::PH_BODY: begin
        pos = blk_len_q - left_q;
        case (pos)
          tbc_pkg::IDX_FLAG:    flag_q = b;
          tbc_pkg::IDX_KIND:    kind_q = b;
          tbc_pkg::IDX_HLEN_LO: hdr_len_q[7:0] = b;
          tbc_pkg::IDX_HLEN_HI: hdr_len_q[15:8] = b;
          tbc_pkg::IDX_HSTA_LO: hdr_start_q[7:0] = b;
          tbc_pkg::IDX_HSTA_HI: hdr_start_q[15:8] = b;
          default: ;
        endcase
        left_q = left_q - 16'd1;
        if (flag_q == tbc_pkg::FLAG_HEADER && blk_len_q == tbc_pkg::HEADER_LEN) begin
          cls = tbc_pkg::CLS_HEADER;
        end else if (flag_q == tbc_pkg::FLAG_DATA) begin
          cls = tbc_pkg::CLS_DATA;
        end else begin
          cls = tbc_pkg::CLS_OTHER;
        end
        if (left_q == 16'd0) begin
          stored = 8'h00;
          st = tbc_pkg::SUM_UNCHECKED;
          if (blk_len_q > 16'd1) begin
            stored = b;
            st = (b == xor_q) ? tbc_pkg::SUM_MATCH : tbc_pkg::SUM_MISMATCH;
          end
          parse_phase = tbc_pkg::PH_LEN_LO;
          close_block(cls, stored, st, '0, eoi, cls == tbc_pkg::CLS_HEADER, rep);
        end else begin
          xor_q = xor_q ^ b;
          if (eoi) begin
            close_block(cls, 8'h00, tbc_pkg::SUM_UNCHECKED, {1'b0, left_q}, 1'b1,
                        1'b0, rep);
          end else begin
            produced = 1'b0;
          end
        end
      end
      default: begin
        len_lo_q = b;
        if (eoi) begin
          // the high length byte counts as zero and is owed along with the body
          blk_len_q = {8'h00, b};
          clear_body();
          close_block((b == 8'h00) ? tbc_pkg::CLS_EMPTY : tbc_pkg::CLS_NOFLAG, 8'h00,
                      tbc_pkg::SUM_UNCHECKED, {9'd0, b} + 17'd1, 1'b1, 1'b0, rep);
        end else begin
          parse_phase = tbc_pkg::PH_LEN_HI;
          produced = 1'b0;
        end
      end
    endcase
  endtask

  function automatic tbc_pkg::result_t typed_report(
      input logic [15:0] num, input tbc_pkg::block_class_t cls,
      input logic [15:0] size, input logic [7:0] flag,
      input logic [7:0] stored, input logic [7:0] comp,
      input tbc_pkg::sum_status_t st, input logic [16:0] missing,
      input logic fin);
    tbc_pkg::result_t r;
    r = '0;
    r.block_number  = num;
    r.block_class   = cls;
    r.data_size     = size;
    r.flag_value    = flag;
    r.stored_sum    = stored;
    r.computed_sum  = comp;
    r.sum_status    = st;
    r.missing_bytes = missing;
    r.final_result  = fin;
    return r;
  endfunction

  task automatic push_beat(input logic [7:0] data);
    tape_beat_t beat;
    beat.data = data;
    beat.eoi = 1'b0;
    beat.typed = 1'b0;
    beat.drain_before = 1'b0;
    beat.want = '0;
    tape_q.push_back(beat);
  endtask

  // length bytes, then up to keep body bytes of a block of len bytes
  task automatic gen_block(input logic [15:0] len, input logic [7:0] flag,
                           input bit good_sum, input int keep);
    logic [7:0] acc;
    logic [7:0] b;
    acc = 8'h00;
    push_beat(len[7:0]);
    push_beat(len[15:8]);
    for (int i = 0; i < int'(len) && i < keep; i++) begin
      if (i == 0) begin
        b = flag;
      end else if (i == int'(len) - 1) begin
        b = good_sum ? acc : 8'($urandom);
      end else begin
        b = 8'($urandom);
      end
      if (i != int'(len) - 1) begin
        acc = acc ^ b;
      end
      push_beat(b);
    end
  endtask

  task automatic compare_field(input string fname, input logic [16:0] want,
                               input logic [16:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %0h, actual %0h", $time, fname, want, got);
    end
  endtask

  task automatic check_report(input tbc_pkg::result_t want);
    compare_field("block_number", want.block_number, out_block_number);
    compare_field("block_class", want.block_class, out_block_class);
    compare_field("data_size", want.data_size, out_data_size);
    compare_field("flag_value", want.flag_value, out_flag_value);
    compare_field("stored_sum", want.stored_sum, out_stored_sum);
    compare_field("computed_sum", want.computed_sum, out_computed_sum);
    compare_field("sum_status", want.sum_status, out_sum_status);
    compare_field("missing_bytes", want.missing_bytes, out_missing_bytes);
    compare_field("header_kind", want.header_kind, out_header_kind);
    compare_field("header_length", want.header_length, out_header_length);
    compare_field("header_start", want.header_start, out_header_start);
    compare_field("final_result", want.final_result, out_final_result);
  endtask

  always @(posedge clk) begin
    tbc_pkg::result_t predicted;
    bit               produced;
    cycle_count++;
    if (rst_n && in_valid && !in_stall) begin
      parse_tape_byte(in_data_byte, in_end_of_image, produced, predicted);
      if (tape_q[in_row].typed) begin
        pending_reports.push_back(tape_q[in_row].want);
      end else if (produced) begin
        pending_reports.push_back(predicted);
      end
    end
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        mismatch_count++;
        $display("%0t: result expected none, actual block_number %0h", $time,
                 out_block_number);
      end else begin
        check_report(pending_reports.pop_front());
      end
    end
    if (stall_span == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_span = $urandom_range(16, 160);
    end else begin
      stall_span--;
    end
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
      STALL_PERIODIC: out_stall <= ((stall_span % 8) < 3);
      default:        out_stall <= ($urandom_range(0, 9) < 7);
    endcase
    if (cycle_count >= cycle_limit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int          idx;
    int          first;
    int          random_count;
    int          nblk;
    int          pick;
    int          style;
    int          keep;
    int          gap;
    int          burst_left;
    bit          good;
    bit          hold;
    logic [15:0] len;
    logic [7:0]  flag;

    restart_image();

    // expectations that read straight off the block format; zero rows go to the predictor
    dir_want[0]  = typed_report(16'd1, tbc_pkg::CLS_EMPTY, 16'd0, 8'h00, 8'h00, 8'h00,
                                tbc_pkg::SUM_UNCHECKED, 17'd1, 1'b1);
    dir_want[1]  = typed_report(16'd1, tbc_pkg::CLS_NOFLAG, 16'd253, 8'h00, 8'h00, 8'h00,
                                tbc_pkg::SUM_UNCHECKED, 17'd256, 1'b1);
    dir_want[3]  = typed_report(16'd1, tbc_pkg::CLS_EMPTY, 16'd0, 8'h00, 8'h00, 8'h00,
                                tbc_pkg::SUM_UNCHECKED, 17'd0, 1'b0);
    dir_want[6]  = typed_report(16'd2, tbc_pkg::CLS_DATA, 16'd0, 8'hff, 8'h00, 8'h00,
                                tbc_pkg::SUM_UNCHECKED, 17'd0, 1'b0);
    dir_want[10] = typed_report(16'd3, tbc_pkg::CLS_OTHER, 16'd0, 8'hab, 8'hab, 8'hab,
                                tbc_pkg::SUM_MATCH, 17'd0, 1'b0);
    dir_want[14] = typed_report(16'd4, tbc_pkg::CLS_OTHER, 16'd0, 8'hab, 8'hac, 8'hab,
                                tbc_pkg::SUM_MISMATCH, 17'd0, 1'b0);
    dir_want[16] = typed_report(16'd5, tbc_pkg::CLS_NOFLAG, 16'd1, 8'h00, 8'h00, 8'h00,
                                tbc_pkg::SUM_UNCHECKED, 17'd3, 1'b1);
    dir_want[22] = typed_report(16'd1, tbc_pkg::CLS_NOFLAG, 16'd65533, 8'h00, 8'h00,
                                8'h00, tbc_pkg::SUM_UNCHECKED, 17'd65535, 1'b1);
    dir_want[24] = typed_report(16'd1, tbc_pkg::CLS_EMPTY, 16'd0, 8'h00, 8'h00, 8'h00,
                                tbc_pkg::SUM_UNCHECKED, 17'd0, 1'b1);
    for (int i = 0; i < DIR_ROWS; i++) begin
      push_beat(DIR_BEATS[i][7:0]);
      tape_q[i].eoi = DIR_BEATS[i][8];
      tape_q[i].typed = (dir_want[i].block_number != 16'd0);
      tape_q[i].want = dir_want[i];
    end

    // a header and a data block closing one image
    first = tape_q.size();
    gen_block(tbc_pkg::HEADER_LEN, tbc_pkg::FLAG_HEADER, 1'b1, 19);
    tape_q[first].drain_before = 1'b1;
    gen_block(16'd5, tbc_pkg::FLAG_DATA, 1'b1, 5);
    tape_q[tape_q.size() - 1].eoi = 1'b1;

    // random images: mostly well-formed blocks, each image ended in one of several ways
    random_count = 0;
    while (random_count < 1450) begin
      first = tape_q.size();
      nblk = $urandom_range(0, 5);
      for (int k = 0; k < nblk; k++) begin
        pick = $urandom_range(0, 99);
        good = ($urandom_range(0, 6) != 0);
        if (pick < 25) begin
          gen_block(tbc_pkg::HEADER_LEN, tbc_pkg::FLAG_HEADER, good, 19);
        end else if (pick < 55) begin
          len = ($urandom_range(0, 49) == 0) ? 16'($urandom_range(200, 1100))
                                              : 16'($urandom_range(2, 40));
          gen_block(len, tbc_pkg::FLAG_DATA, good, int'(len));
        end else if (pick < 65) begin
          gen_block(16'($urandom_range(2, 30)), 8'($urandom), good, 30);
        end else if (pick < 72) begin
          gen_block(16'd0, 8'h00, good, 0);
        end else if (pick < 78) begin
          gen_block(16'd1, 8'($urandom), good, 1);
        end else if (pick < 84) begin
          // header flag with a length just off the header size
          gen_block(($urandom_range(0, 1) != 0) ? 16'd18 : 16'd20, tbc_pkg::FLAG_HEADER,
                    good, 20);
        end else begin
          len = 16'($urandom_range(0, 60));
          gen_block(len, 8'($urandom), good, int'(len));
        end
      end
      style = $urandom_range(0, 99);
      if (style < 62) begin
        if (nblk == 0) begin
          gen_block(tbc_pkg::HEADER_LEN, tbc_pkg::FLAG_HEADER, 1'b1, 19);
        end
      end else if (style < 74) begin
        case ($urandom_range(0, 3))
          0:       len = 16'($urandom);
          1:       len = tbc_pkg::HEADER_LEN;
          default: len = 16'($urandom_range(2, 40));
        endcase
        if (len < 16'd2) begin
          len = 16'd2;
        end
        if (len == tbc_pkg::HEADER_LEN) begin
          flag = tbc_pkg::FLAG_HEADER;
        end else begin
          flag = ($urandom_range(0, 1) != 0) ? tbc_pkg::FLAG_DATA : 8'($urandom);
        end
        keep = $urandom_range(1, (len > 16'd25) ? 24 : int'(len) - 1);
        gen_block(len, flag, 1'b1, keep);
      end else if (style < 80) begin
        push_beat(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
      end else if (style < 88) begin
        len = ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
        push_beat(len[7:0]);
        push_beat(len[15:8]);
      end else begin
        repeat ($urandom_range(1, 30)) push_beat(8'($urandom));
      end
      tape_q[tape_q.size() - 1].eoi = 1'b1;
      if (random_count == 0 || $urandom_range(0, 24) == 0) begin
        tape_q[first].drain_before = 1'b1;
      end
      random_count += tape_q.size() - first;
    end

    cycle_limit = 50 * tape_q.size() + 20000;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    idx = 0;
    burst_left = $urandom_range(1, 30);
    while (idx < tape_q.size()) begin
      in_valid        <= 1'b1;
      in_data_byte    <= tape_q[idx].data;
      in_end_of_image <= tape_q[idx].eoi;
      in_row          <= idx;
      @(posedge clk);
      while (in_stall !== 1'b0) @(posedge clk);
      idx++;
      gap = 0;
      burst_left--;
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 600)
                                                 : $urandom_range(1, 30);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end
      hold = (gap != 0) || (idx >= tape_q.size());
      if (idx < tape_q.size()) begin
        hold = hold || tape_q[idx].drain_before;
      end
      if (hold) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
        if (idx < tape_q.size() && tape_q[idx].drain_before) begin
          // hold off until every report owed so far has come out
          do @(posedge clk); while (pending_reports.size() != 0);
        end
      end
    end

    do @(posedge clk); while (pending_reports.size() != 0);
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
